// File: hw/rtl/tcs_pkg.sv
package tcs_pkg;

  // Item actions
  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_STORE = 3'd1,
    ACT_RUN   = 3'd2,
    ACT_CLEAR = 3'd3,
    ACT_STOP  = 3'd4
  } action_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_SLOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_FAST    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION_UNIT = 2'd2;

  localparam logic [15:0] BLINK_SLOW_RESET    = 16'd500;
  localparam logic [15:0] BLINK_FAST_RESET    = 16'd50;
  localparam logic [7:0]  DURATION_UNIT_RESET = 8'd100;

  localparam int unsigned LIST_DEPTH_DEF = 16;

  // Field widths
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned KIND_W   = 4;
  localparam int unsigned DUR_W    = 8;
  localparam int unsigned ENTRY_W  = KIND_W + DUR_W;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;

  typedef struct packed {
    logic [15:0] blink_slow;
    logic [15:0] blink_fast;
    logic [7:0]  duration_unit;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] stored_count;
    logic               running;
    logic               accepting;
    logic               led_level;
    logic [DUR_W-1:0]   issued_duration;
    logic [KIND_W-1:0]  issued_kind;
    logic [INDEX_W-1:0] issued_index;
    logic               issue_valid;
  } result_t;

endpackage

// File: hw/rtl/timed_command_sequencer_core.sv
// Timed command sequencer. Store items append a motion command (kind and
// duration) to a list while the block is accepting and the list is not
// full; a run item switches to executing, where tick items issue the
// stored commands in order, each held for duration * duration_unit_ticks
// ticks, and the block falls back to accepting after the last one. Clear
// empties the list and, like stop, returns to accepting. An activity LED
// toggles every blink_slow_ticks ticks while accepting and every
// blink_fast_ticks ticks while executing. Every input item yields exactly
// one result item showing the state after that item. Throughput is one
// item per cycle while the result side keeps tready high. Each item passes
// through the input register, the combinational update logic and the
// result register on its way to the result side. The command list
// is a memory with one write port and a registered read port that always
// holds the entry the next issue will use. Configuration writes take effect
// at the next timer reload and should be made while the block is idle.
module timed_command_sequencer_core
  import tcs_pkg::*;
#(
  parameter int unsigned ListDepth = LIST_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // tdata: action[2:0], command_kind[6:3], command_duration[14:7]
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tdata: issue_valid[0], issued_index[4:1], issued_kind[8:5],
  //        issued_duration[16:9], led_level[17], accepting[18],
  //        running[19], stored_count[24:20]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [15:0]            cfg_wdata_i
);

  cfg_t cfg_q;

  logic                in_valid_q;
  logic [ACTION_W-1:0] in_action_q;
  logic [KIND_W-1:0]   in_kind_q;
  logic [DUR_W-1:0]    in_dur_q;

  logic    out_valid_q;
  result_t out_res_q;
  result_t res;

  logic advance;
  logic in_take;

  // Update the state and load the result register when an input item is held
  // and the result slot is free or being drained this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink_slow    <= BLINK_SLOW_RESET;
      cfg_q.blink_fast    <= BLINK_FAST_RESET;
      cfg_q.duration_unit <= DURATION_UNIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BLINK_SLOW:    cfg_q.blink_slow    <= cfg_wdata_i;
        REG_BLINK_FAST:    cfg_q.blink_fast    <= cfg_wdata_i;
        REG_DURATION_UNIT: cfg_q.duration_unit <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_action_q <= s_axis_tdata[2:0];
      in_kind_q   <= s_axis_tdata[6:3];
      in_dur_q    <= s_axis_tdata[14:7];
    end
  end

  tcs_engine #(
    .ListDepth(ListDepth)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(advance),
    .action_i    (in_action_q),
    .kind_i      (in_kind_q),
    .duration_i  (in_dur_q),
    .cfg_i       (cfg_q),
    .result_o    (res)
  );

  // Result register: hold until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, out_res_q};

endmodule

// File: hw/rtl/tcs_engine.sv
module tcs_engine
  import tcs_pkg::*;
#(
  parameter int unsigned ListDepth = LIST_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  logic [2:0]        action_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [DUR_W-1:0]  duration_i,
  input  cfg_t              cfg_i,
  output result_t           result_o
);

  localparam int unsigned CntW  = $clog2(ListDepth + 1);
  localparam int unsigned AddrW = (ListDepth > 1) ? $clog2(ListDepth) : 1;

  logic [ENTRY_W-1:0] mem [ListDepth];

  logic              run_mode_q, run_mode_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   pos_q, pos_d;
  logic              before_first_q, before_first_d;
  logic [15:0]       blink_q, blink_d;
  logic [15:0]       step_q, step_d;
  logic              led_bit_q, led_bit_d;
  logic              pin_q, pin_d;
  logic [ENTRY_W-1:0] look_q;

  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [AddrW-1:0]  rd_addr;
  logic [CntW-1:0]   rd_pos;
  logic              bf_next;
  logic [CntW-1:0]   pos_next;

  logic [15:0]       blink_dec;
  logic [15:0]       step_dec;
  logic [CntW-1:0]   npos;
  logic              issue;
  logic [15:0]       product;
  logic [31:0]       npos_ext;
  logic [31:0]       count_ext;

  assign blink_dec = (blink_q != 16'd0) ? blink_q - 16'd1 : 16'd0;
  assign step_dec  = (step_q != 16'd0) ? step_q - 16'd1 : 16'd0;
  assign npos      = before_first_q ? '0 : pos_q + CntW'(1);
  assign product   = {8'd0, look_q[DUR_W-1:0]} * {8'd0, cfg_i.duration_unit};
  assign wr_data   = {kind_i, duration_i};
  assign wr_addr   = count_q[AddrW-1:0];

  always_comb begin
    run_mode_d     = run_mode_q;
    count_d        = count_q;
    pos_d          = pos_q;
    before_first_d = before_first_q;
    blink_d        = blink_q;
    step_d         = step_q;
    led_bit_d      = led_bit_q;
    pin_d          = pin_q;
    wr_en          = 1'b0;
    issue          = 1'b0;
    unique case (action_e'(action_i))
      ACT_TICK: begin
        if (blink_dec == 16'd0) begin
          pin_d     = led_bit_q;
          led_bit_d = ~led_bit_q;
          blink_d   = run_mode_q ? cfg_i.blink_fast : cfg_i.blink_slow;
        end else begin
          blink_d = blink_dec;
        end
        if (run_mode_q) begin
          step_d = step_dec;
          if (step_dec == 16'd0) begin
            before_first_d = 1'b0;
            pos_d          = npos;
            if (npos >= count_q) begin
              // list exhausted: back to accepting
              run_mode_d = 1'b0;
              blink_d    = cfg_i.blink_slow;
            end else begin
              issue  = 1'b1;
              step_d = product;
            end
          end
        end
      end
      ACT_STORE: begin
        if (!run_mode_q && (count_q < CntW'(ListDepth))) begin
          wr_en   = 1'b1;
          count_d = count_q + CntW'(1);
        end
      end
      ACT_RUN: begin
        run_mode_d     = 1'b1;
        before_first_d = 1'b1;
        step_d         = 16'd0;
        blink_d        = cfg_i.blink_fast;
      end
      ACT_CLEAR: begin
        count_d    = '0;
        pos_d      = '0;
        run_mode_d = 1'b0;
        blink_d    = cfg_i.blink_slow;
      end
      ACT_STOP: begin
        run_mode_d = 1'b0;
        blink_d    = cfg_i.blink_slow;
      end
      default: begin
      end
    endcase
  end

  // Lookahead read: keep the entry that the next issue would use.
  assign bf_next  = item_valid_i ? before_first_d : before_first_q;
  assign pos_next = item_valid_i ? pos_d : pos_q;
  assign rd_pos   = bf_next ? '0 : pos_next + CntW'(1);
  assign rd_addr  = rd_pos[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (item_valid_i && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (item_valid_i && wr_en && (wr_addr == rd_addr)) begin
      look_q <= wr_data;
    end else begin
      look_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mode_q     <= 1'b0;
      count_q        <= '0;
      pos_q          <= '0;
      before_first_q <= 1'b0;
      blink_q        <= BLINK_SLOW_RESET;
      step_q         <= 16'd0;
      led_bit_q      <= 1'b0;
      pin_q          <= 1'b0;
    end else if (item_valid_i) begin
      run_mode_q     <= run_mode_d;
      count_q        <= count_d;
      pos_q          <= pos_d;
      before_first_q <= before_first_d;
      blink_q        <= blink_d;
      step_q         <= step_d;
      led_bit_q      <= led_bit_d;
      pin_q          <= pin_d;
    end
  end

  assign npos_ext  = 32'(npos);
  assign count_ext = 32'(count_d);

  always_comb begin
    result_o                 = '0;
    result_o.issue_valid     = issue;
    if (issue) begin
      result_o.issued_index    = npos_ext[INDEX_W-1:0];
      result_o.issued_kind     = look_q[ENTRY_W-1:DUR_W];
      result_o.issued_duration = look_q[DUR_W-1:0];
    end
    result_o.led_level    = pin_d;
    result_o.accepting    = ~run_mode_d;
    result_o.running      = run_mode_d;
    result_o.stored_count = count_ext[COUNT_W-1:0];
  end

endmodule

// File: hw/rtl/tcs_checker.sv
module tcs_checker
  import tcs_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // An issued command only comes while executing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[19])
    else $error("issue outside execute mode");

  // Exactly one of accepting and running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[18] != m_axis_tdata[19]))
    else $error("mode flags inconsistent");

  // With the result slot empty the input side never stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result slot");

endmodule

bind timed_command_sequencer_core tcs_checker u_tcs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// File: sim/tb_timed_command_sequencer_core.sv
`timescale 1ns / 1ps

module tb_timed_command_sequencer_core;
  import tcs_pkg::*;

  // Action codes the block decodes to nothing.
  localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;

  // Tracks the sequencer state item by item and holds the status items it
  // must report, oldest first.
  class sequencer_tracker;
    logic [15:0]        slow_period;
    logic [15:0]        fast_period;
    logic [7:0]         unit_ticks;
    bit                 executing;
    bit                 before_first;
    bit                 led_bit;
    bit                 pin_level;
    logic [COUNT_W-1:0] list_count;
    logic [COUNT_W-1:0] exec_pos;
    logic [ENTRY_W-1:0] command_list [LIST_DEPTH_DEF];
    logic [15:0]        blink_timer;
    logic [15:0]        step_timer;
    result_t            expected_q [$];
    int unsigned        n_errors;
    int unsigned        n_checked;
    int unsigned        n_issued;
    int unsigned        n_full_drops;

    function new();
      slow_period  = BLINK_SLOW_RESET;
      fast_period  = BLINK_FAST_RESET;
      unit_ticks   = DURATION_UNIT_RESET;
      executing    = 1'b0;
      before_first = 1'b0;
      led_bit      = 1'b0;
      pin_level    = 1'b0;
      list_count   = '0;
      exec_pos     = '0;
      blink_timer  = BLINK_SLOW_RESET;
      step_timer   = '0;
      n_errors     = 0;
      n_checked    = 0;
      n_issued     = 0;
      n_full_drops = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        REG_BLINK_SLOW:    slow_period = val;
        REG_BLINK_FAST:    fast_period = val;
        REG_DURATION_UNIT: unit_ticks  = val[7:0];
        default: ;
      endcase
    endfunction

    function void enter_accept();
      executing   = 1'b0;
      blink_timer = slow_period;
    endfunction

    function void enter_exec();
      executing    = 1'b1;
      before_first = 1'b1;
      step_timer   = '0;
      blink_timer  = fast_period;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted item and queue the status it must produce.
    function void note_item(logic [ACTION_W-1:0] act, logic [KIND_W-1:0] kind,
                            logic [DUR_W-1:0] dur);
      result_t            want;
      logic [ENTRY_W-1:0] entry;
      want = '0;
      case (act)
        ACT_TICK: begin
          if (blink_timer != 0) blink_timer--;
          if (blink_timer == 0) begin
            pin_level   = led_bit;
            led_bit     = !led_bit;
            blink_timer = executing ? fast_period : slow_period;
          end
          if (executing) begin
            if (step_timer != 0) step_timer--;
            if (step_timer == 0) begin
              if (before_first) begin
                exec_pos     = '0;
                before_first = 1'b0;
              end else begin
                exec_pos++;
              end
              if (exec_pos >= list_count) begin
                enter_accept();
              end else begin
                entry                = command_list[exec_pos[INDEX_W-1:0]];
                want.issue_valid     = 1'b1;
                want.issued_index    = exec_pos[INDEX_W-1:0];
                want.issued_kind     = entry[ENTRY_W-1:DUR_W];
                want.issued_duration = entry[DUR_W-1:0];
                step_timer           = 16'(entry[DUR_W-1:0]) * 16'(unit_ticks);
                n_issued++;
              end
            end
          end
        end
        ACT_STORE: begin
          if (!executing && list_count < LIST_DEPTH_DEF) begin
            command_list[list_count[INDEX_W-1:0]] = {kind, dur};
            list_count++;
          end else if (!executing) begin
            n_full_drops++;
          end
        end
        ACT_RUN: enter_exec();
        ACT_CLEAR: begin
          list_count = '0;
          exec_pos   = '0;
          enter_accept();
        end
        ACT_STOP: enter_accept();
        default: ;
      endcase
      want.led_level    = pin_level;
      want.accepting    = !executing;
      want.running      = executing;
      want.stored_count = list_count;
      expected_q.push_back(want);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        n_errors++;
      end
    endfunction

    function void check_status(result_t got);
      result_t want;
      n_checked++;
      if (expected_q.size() == 0) begin
        $display("%0t: status item %h arrived with nothing expected", $time, got);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("issue_valid", 16'(want.issue_valid), 16'(got.issue_valid));
      compare_field("issued_index", 16'(want.issued_index), 16'(got.issued_index));
      compare_field("issued_kind", 16'(want.issued_kind), 16'(got.issued_kind));
      compare_field("issued_duration", 16'(want.issued_duration),
                    16'(got.issued_duration));
      compare_field("led_level", 16'(want.led_level), 16'(got.led_level));
      compare_field("accepting", 16'(want.accepting), 16'(got.accepting));
      compare_field("running", 16'(want.running), 16'(got.running));
      compare_field("stored_count", 16'(want.stored_count), 16'(got.stored_count));
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // tdata: action[2:0], command_kind[6:3], command_duration[14:7]
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // tdata: issue_valid[0], issued_index[4:1], issued_kind[8:5],
  //        issued_duration[16:9], led_level[17], accepting[18],
  //        running[19], stored_count[24:20]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [15:0]            cfg_wdata_i   = '0;

  sequencer_tracker sequencer = new();
  int unsigned      n_items = 0;
  bit               sender_steady = 1'b0;

  timed_command_sequencer_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Check every status item at the edge it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sequencer.check_status(result_t'(m_axis_tdata[$bits(result_t)-1:0]));
  end

  // Result side: stall a random number of cycles before taking each item,
  // with occasional stretches that never stall.
  initial begin : result_sink
    int unsigned stall;
    bit          steady;
    steady = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 29) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Present one item after a random gap and hold it until it is taken.
  // Keep tvalid high across back-to-back items; drop it only for a gap.
  task automatic send_item(logic [ACTION_W-1:0] act, logic [KIND_W-1:0] kind,
                           logic [DUR_W-1:0] dur);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) sender_steady = !sender_steady;
    gap = sender_steady ? 0 : $urandom_range(0, 17);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, dur, kind, act};
    do @(posedge clk_i); while (!s_axis_tready);
    sequencer.note_item(act, kind, dur);
    if (act <= ACT_STOP) n_items++;
  endtask

  // Any action, unused codes included, with random payload.
  task automatic send_noise();
    send_item(ACTION_W'($urandom_range(0, ACT_UNUSED_LAST)), KIND_W'($urandom),
              DUR_W'($urandom));
  endtask

  // Mostly short holds so programs finish; now and then any duration.
  function automatic logic [DUR_W-1:0] pick_duration();
    return ($urandom_range(0, 9) == 0) ? DUR_W'($urandom_range(0, 255))
                                       : DUR_W'($urandom_range(0, 3));
  endfunction

  // Drop tvalid and hold off until every status item is back, plus slack
  // for the input and result registers.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sequencer.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sequencer.write_reg(idx, val);
  endtask

  // Reprogram only with the pipeline empty.
  task automatic set_config(logic [15:0] slow, logic [15:0] fast, logic [7:0] unit);
    drain();
    write_reg(REG_BLINK_SLOW, slow);
    write_reg(REG_BLINK_FAST, fast);
    write_reg(REG_DURATION_UNIT, {8'h00, unit});
  endtask

  // Random part: mostly complete programs (clear, fill, run, tick until the
  // list is done or a cutoff), sometimes overfilling the list, with stray
  // items mixed in and runs cut short by stop or clear.
  task automatic run_programs(int unsigned quota);
    int unsigned goal;
    int unsigned n_cmds;
    int unsigned cutoff;
    int unsigned ticks;
    goal = n_items + quota;
    while (n_items < goal) begin
      if ($urandom_range(0, 99) < 75) begin
        if ($urandom_range(0, 3) != 0)
          send_item(ACT_CLEAR, KIND_W'($urandom), DUR_W'($urandom));
        n_cmds = ($urandom_range(0, 5) == 0)
               ? $urandom_range(LIST_DEPTH_DEF, LIST_DEPTH_DEF + 4)
               : $urandom_range(0, 6);
        repeat (n_cmds) begin
          if ($urandom_range(0, 15) == 0) send_noise();
          send_item(ACT_STORE, KIND_W'($urandom), pick_duration());
        end
        send_item(ACT_RUN, KIND_W'($urandom), DUR_W'($urandom));
        cutoff = $urandom_range(10, 300);
        ticks  = 0;
        while (sequencer.executing && ticks < cutoff) begin
          if ($urandom_range(0, 59) == 0) send_noise();
          else send_item(ACT_TICK, KIND_W'($urandom), DUR_W'($urandom));
          ticks++;
        end
        // Abort a run that outlived its cutoff.
        if (sequencer.executing)
          send_item($urandom_range(0, 1) ? ACT_STOP : ACT_CLEAR,
                    KIND_W'($urandom), DUR_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 8)) send_noise();
      end
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the shortest periods so every step shows up fast.
    set_config(16'd1, 16'd1, 8'd1);
    send_item(ACT_TICK, 4'hF, 8'hFF);
    send_item(ACT_RUN, 4'h0, 8'h00);     // run with an empty list
    send_item(ACT_TICK, 4'h0, 8'h00);    // falls straight back to accepting
    send_item(ACT_STORE, 4'h0, 8'h00);   // zero-length command
    send_item(ACT_STORE, 4'hA, 8'h02);
    send_item(ACT_STORE, 4'hF, 8'hFF);
    for (int a = ACT_UNUSED_FIRST; a <= ACT_UNUSED_LAST; a++)
      send_item(ACTION_W'(a), KIND_W'($urandom), DUR_W'($urandom));
    send_item(ACT_RUN, 4'h5, 8'h55);
    send_item(ACT_TICK, 4'h0, 8'h00);    // issue entry 0
    send_item(ACT_TICK, 4'h0, 8'h00);    // zero hold: issue entry 1 at once
    send_item(ACT_STORE, 4'h3, 8'h03);   // ignored while executing
    send_item(ACT_TICK, 4'h0, 8'h00);
    send_item(ACT_TICK, 4'h0, 8'h00);    // issue entry 2
    send_item(ACT_RUN, 4'h0, 8'h00);     // restart the list mid-run
    send_item(ACT_TICK, 4'h0, 8'h00);
    send_item(ACT_STOP, 4'h0, 8'h00);
    send_item(ACT_TICK, 4'h0, 8'h00);
    send_item(ACT_CLEAR, 4'h0, 8'h00);
    send_item(ACT_RUN, 4'h0, 8'h00);
    send_item(ACT_TICK, 4'h0, 8'h00);
    send_item(ACT_STOP, 4'h0, 8'h00);    // stop while already accepting

    set_config(16'd9, 16'd3, 8'd2);
    run_programs(400);
    set_config(16'hFFFF, 16'hFFFF, 8'hFF);
    run_programs(300);
    set_config(16'd1, 16'd2, 8'd1);
    run_programs(400);
    set_config(16'($urandom_range(2, 200)), 16'($urandom_range(1, 30)),
               8'($urandom_range(1, 8)));
    run_programs(350);

    drain();
    repeat (8) @(posedge clk_i);
    $display("run covered %0d items over five register settings, %0d status items checked",
             n_items, sequencer.n_checked);
    $display("%0d commands issued, %0d stores refused by a full list",
             sequencer.n_issued, sequencer.n_full_drops);
    if (sequencer.n_errors == 0 && sequencer.pending() == 0) begin
      $display("timed_command_sequencer_core: match");
    end else begin
      $display("timed_command_sequencer_core: mismatch");
    end
    $finish;
  end

  // Watchdog: a stuck handshake or a missing status item ends here.
  initial begin
    #5_000_000;
    $display("timed_command_sequencer_core: mismatch");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/tcs_pkg.sv
hw/rtl/tcs_engine.sv
hw/rtl/timed_command_sequencer_core.sv
hw/rtl/tcs_checker.sv
sim/tb_timed_command_sequencer_core.sv
